FILE: rtl/txopm_pkg.sv
`timescale 1ns / 1ps

package txopm_pkg;

  // Field widths of one poll pass and of one result.
  localparam int unsigned LaserW  = 4;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned PerW    = 11;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 72;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Default refresh multiplier: passes per five seconds times this gives the period.
  localparam int unsigned RefreshMultDefault = 36;

  // Longest refresh period the 16-bit pass counter supports.
  localparam logic [16:0] PeriodMax = 17'h10000;

  // Register reset values.
  localparam logic signed [SampleW-1:0] DefectThrReset = -16'sd1000;
  localparam logic signed [SampleW-1:0] ClearThrReset  = -16'sd900;
  localparam logic [SampleW-1:0]        StepThrReset   = 16'd100;
  localparam logic signed [SampleW-1:0] AbsentReset    = -16'sd32768;
  localparam logic [PerW-1:0]           PerReset       = 11'd25;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    RegDefectThr = 3'd0,
    RegClearThr  = 3'd1,
    RegStepThr   = 3'd2,
    RegAbsent    = 3'd3,
    RegPer       = 3'd4
  } cfg_reg_e;

  // Which reading a pass stores.
  typedef enum logic [1:0] {
    PhaseBias  = 2'd0,
    PhaseTemp  = 2'd1,
    PhasePower = 2'd2
  } phase_e;

endpackage

FILE: rtl/txopm_refresh.sv
`timescale 1ns / 1ps

module txopm_refresh #(
  parameter int unsigned REFRESH_MULT = txopm_pkg::RefreshMultDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [txopm_pkg::PerW-1:0] per_i,
  output logic                       refresh_o
);
  import txopm_pkg::*;

  localparam int unsigned MultW = $clog2(REFRESH_MULT + 1);
  localparam int unsigned ProdW = PerW + MultW;
  localparam int unsigned CmpW  = (ProdW > 17) ? ProdW : 17;

  logic [PerW-1:0]   per_eff;
  logic [ProdW-1:0]  prod;
  logic [CmpW-1:0]   prod_ext;
  logic [16:0]       period;
  logic [16:0]       count_inc;
  logic [CountW-1:0] count_d, count_q;

  // A per_i value of zero is treated as one.
  assign per_eff  = (per_i == '0) ? PerW'(1) : per_i;
  assign prod     = ProdW'(per_eff) * ProdW'(REFRESH_MULT);
  assign prod_ext = CmpW'(prod);

  // Clip the period to what the pass counter can reach.
  assign period = (prod_ext > CmpW'(PeriodMax)) ? PeriodMax : 17'(prod_ext);

  // The refresh fires as soon as the next count reaches the period.
  assign count_inc = {1'b0, count_q} + 17'd1;
  assign refresh_o = (count_inc >= period);
  assign count_d   = refresh_o ? '0 : count_inc[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/tx_optical_power_monitor.sv
`timescale 1ns / 1ps

// Transmit optical power monitor.
// Each transaction on the s_axis channel is one poll pass of a transmit laser;
// tuser carries the read-error flag of that pass. Every pass yields exactly one
// result transaction on the m_axis channel with the stored readings, the
// low-power defect, the status-valid flag, the change flag and the change count.
// Passes rotate through bias, temperature and power; the first pass after reset
// stores temperature. The power pass checks for a large step and runs the
// defect hysteresis.
// The result is registered: a pass accepted in one cycle has its result valid in
// the next. One pass is accepted every cycle while the receiver does not stall,
// set by the single result register that also holds the monitor state; a new pass
// is taken in the same cycle that the waiting result is taken.
// When the receiver stalls, the result holds and s_axis_tready drops until it is
// taken. Reset clears the state, sets the stored power to the absent value, loads the
// register defaults and leaves no result pending. The cfg channel is always ready
// and should only be written while no result is pending.
module tx_optical_power_monitor #(
  parameter int unsigned REFRESH_MULT = txopm_pkg::RefreshMultDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Poll pass input.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // laser_state_in[3:0], bias_in[19:4], temp_in[35:20], power_in[51:36], zero pad
  input  logic [txopm_pkg::InDataW-1:0]  s_axis_tdata,
  // read_error
  input  logic                           s_axis_tuser,
  // Result output.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // laser_state_out[3:0], bias_out[19:4], temp_out[35:20], power_out[51:36],
  // low_power_defect[52], status_valid[53], changed[54], change_count[70:55], zero pad
  output logic [txopm_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [txopm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [txopm_pkg::CfgDataW-1:0] cfg_data_i
);
  import txopm_pkg::*;

  // Configuration registers.
  logic signed [SampleW-1:0] defect_thr_q, clear_thr_q, absent_q;
  logic [SampleW-1:0]        step_thr_q;
  logic [PerW-1:0]           per_q;

  // Monitor state, which doubles as the result register.
  logic [LaserW-1:0]         laser_q, laser_d;
  logic [SampleW-1:0]        bias_q, bias_d;
  logic signed [SampleW-1:0] temp_q, temp_d;
  logic signed [SampleW-1:0] power_q, power_d;
  logic                      defect_q, defect_d;
  logic                      valid_q, valid_d;
  logic                      changed_q, changed_d;
  logic [CountW-1:0]         count_q, count_d;
  phase_e                    phase_q, phase_d;
  logic                      out_valid_q;

  // Decoded input fields.
  logic [LaserW-1:0]         laser_in;
  logic [SampleW-1:0]        bias_in;
  logic signed [SampleW-1:0] temp_in;
  logic signed [SampleW-1:0] power_in;
  logic                      rd_err;

  logic                      accept;
  logic                      refresh;
  logic signed [SampleW:0]   power_diff;
  logic [SampleW:0]          power_abs;
  logic                      big_step;
  logic                      defect_new;

  assign laser_in = s_axis_tdata[3:0];
  assign bias_in  = s_axis_tdata[19:4];
  assign temp_in  = s_axis_tdata[35:20];
  assign power_in = s_axis_tdata[51:36];
  assign rd_err   = s_axis_tuser;

  // A pass enters when the result slot is empty or drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  txopm_refresh #(
    .REFRESH_MULT(REFRESH_MULT)
  ) u_refresh (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(accept),
    .per_i    (per_q),
    .refresh_o(refresh)
  );

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      defect_thr_q <= DefectThrReset;
      clear_thr_q  <= ClearThrReset;
      step_thr_q   <= StepThrReset;
      absent_q     <= AbsentReset;
      per_q        <= PerReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDefectThr: defect_thr_q <= cfg_data_i;
        RegClearThr:  clear_thr_q  <= cfg_data_i;
        RegStepThr:   step_thr_q   <= cfg_data_i;
        RegAbsent:    absent_q     <= cfg_data_i;
        RegPer:       per_q        <= cfg_data_i[PerW-1:0];
        default: ;
      endcase
    end
  end

  // Next phase; the unused code returns to the bias phase.
  always_comb begin
    case (phase_q)
      PhaseBias: phase_d = PhaseTemp;
      PhaseTemp: phase_d = PhasePower;
      default:   phase_d = PhaseBias;
    endcase
  end

  // Power step magnitude against the stored power.
  assign power_diff = 17'(signed'(power_in)) - 17'(signed'(power_q));
  assign power_abs  = power_diff[SampleW] ? 17'(-power_diff) : 17'(power_diff);
  assign big_step   = (power_in != power_q) && (power_abs >= {1'b0, step_thr_q});

  // Defect hysteresis, forced off for the sentinel or an invalid status.
  always_comb begin
    if (power_in == absent_q || !valid_q) begin
      defect_new = 1'b0;
    end else if (power_in < defect_thr_q) begin
      defect_new = 1'b1;
    end else if (power_in > clear_thr_q) begin
      defect_new = 1'b0;
    end else begin
      defect_new = defect_q;
    end
  end

  // State update for one pass; a read error invalidates the status and stores no reading.
  always_comb begin
    laser_d   = laser_q;
    bias_d    = bias_q;
    temp_d    = temp_q;
    power_d   = power_q;
    defect_d  = defect_q;
    valid_d   = 1'b0;
    changed_d = 1'b0;
    if (!rd_err) begin
      valid_d   = 1'b1;
      laser_d   = laser_in;
      changed_d = (laser_in != laser_q) || refresh;
      case (phase_d)
        PhaseBias: bias_d = bias_in;
        PhaseTemp: temp_d = temp_in;
        default: begin
          power_d   = power_in;
          defect_d  = defect_new;
          changed_d = changed_d || big_step || (defect_new != defect_q);
        end
      endcase
    end
    count_d = changed_d ? count_q + CountW'(1) : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      laser_q   <= '0;
      bias_q    <= '0;
      temp_q    <= '0;
      power_q   <= AbsentReset;
      defect_q  <= 1'b0;
      valid_q   <= 1'b0;
      changed_q <= 1'b0;
      count_q   <= '0;
      phase_q   <= PhaseBias;
    end else if (accept) begin
      laser_q   <= laser_d;
      bias_q    <= bias_d;
      temp_q    <= temp_d;
      power_q   <= power_d;
      defect_q  <= defect_d;
      valid_q   <= valid_d;
      changed_q <= changed_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
    end
  end

  // Result slot occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, count_q, changed_q, valid_q, defect_q,
                          power_q, temp_q, bias_q, laser_q};

endmodule
